FILE: rtl/free_number_allocator_defines.svh
// assertion macros for the free number allocator checker
// depends on aclk and aresetn being visible where the macros are used
`ifndef FREE_NUMBER_ALLOCATOR_DEFINES_SVH
`define FREE_NUMBER_ALLOCATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define FNA_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define FNA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/fna_pkg.sv
// shared types and constants of the free number allocator
// no dependencies
package fna_pkg;

    localparam int POOL_DEPTH = 1024;
    localparam int NUM_W      = 10;
    localparam int SIZE_W     = 11;
    localparam int WORD_W     = 32;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int N_WORDS    = POOL_DEPTH / WORD_W;
    localparam int WADDR_W    = $clog2(N_WORDS);

    localparam logic [1:0] CMD_GET     = 2'd0;
    localparam logic [1:0] CMD_CHECK   = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [NUM_W-1:0] number;
    } req_t;

    typedef struct packed {
        logic [NUM_W-1:0] granted_number;
        logic             granted;
        logic             is_free;
        logic             bad_number;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit;
    } ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EVAL = 3'b100
    } state_t;

endpackage

FILE: rtl/fna_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module fna_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/fna_ctrl.sv
// sequencing state machine and result valid of the free number allocator
// depends on fna_pkg
module fna_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output fna_pkg::ctl_t ctl
);

    fna_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;

    always_comb begin
        ctl.load   = s_valid && (state_reg == fna_pkg::ST_IDLE);
        ctl.rd_en  = (state_reg == fna_pkg::ST_READ);
        // result register must be empty or draining before we commit
        ctl.commit = (state_reg == fna_pkg::ST_EVAL) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fna_pkg::ST_IDLE: begin
                if (ctl.load) begin
                    state_next = fna_pkg::ST_READ;
                end
            end
            fna_pkg::ST_READ: begin
                state_next = fna_pkg::ST_EVAL;
            end
            fna_pkg::ST_EVAL: begin
                if (ctl.commit) begin
                    state_next = fna_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fna_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (ctl.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fna_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == fna_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

FILE: rtl/fna_datapath.sv
// bitmap storage, lowest free search and result register of the allocator
// depends on fna_pkg and fna_ram
module fna_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  fna_pkg::ctl_t              ctl,
    input  fna_pkg::req_t              s_payload,
    input  logic                       cfg_we,
    input  logic [fna_pkg::SIZE_W-1:0] cfg_wdata,
    output fna_pkg::rsp_t              m_payload
);

    logic [fna_pkg::SIZE_W-1:0]  pool_size_reg;
    fna_pkg::req_t               req_reg;
    logic [fna_pkg::WADDR_W-1:0] waddr_reg;
    logic                        any_free_reg;
    logic [fna_pkg::N_WORDS-1:0] valid_reg;
    logic [fna_pkg::N_WORDS-1:0] summary_reg;
    fna_pkg::rsp_t               rsp_reg, rsp_next;

    logic [fna_pkg::SIZE_W-1:0]  size_eff;
    logic [fna_pkg::WADDR_W-1:0] first_word;
    logic [fna_pkg::WORD_W-1:0]  rdata;
    logic [fna_pkg::WORD_W-1:0]  word_data;
    logic [fna_pkg::WORD_W-1:0]  pool_mask;
    logic [fna_pkg::WORD_W-1:0]  cand;
    logic [fna_pkg::BIT_W-1:0]   low_bit;
    logic                        cand_any;
    logic [fna_pkg::BIT_W-1:0]   bit_idx;
    logic                        bad;
    logic                        wr;
    logic [fna_pkg::WORD_W-1:0]  wdata;

    assign size_eff = (pool_size_reg > fna_pkg::SIZE_W'(fna_pkg::POOL_DEPTH))
                    ? fna_pkg::SIZE_W'(fna_pkg::POOL_DEPTH) : pool_size_reg;

    // lowest word that still holds a free bit
    always_comb begin
        first_word = '0;
        for (int i = fna_pkg::N_WORDS - 1; i >= 0; i--) begin
            if (summary_reg[i]) begin
                first_word = fna_pkg::WADDR_W'(i);
            end
        end
    end

    fna_ram #(
        .WIDTH (fna_pkg::WORD_W),
        .DEPTH (fna_pkg::N_WORDS)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (ctl.commit && wr),
        .waddr (waddr_reg),
        .wdata (wdata),
        .re    (ctl.rd_en),
        .raddr (waddr_reg),
        .rdata (rdata)
    );

    // a word never written since reset is all free
    assign word_data = valid_reg[waddr_reg] ? rdata : '1;

    always_comb begin
        for (int b = 0; b < fna_pkg::WORD_W; b++) begin
            pool_mask[b] = {1'b0, waddr_reg, fna_pkg::BIT_W'(b)} < size_eff;
        end
    end

    assign cand = word_data & pool_mask;

    always_comb begin
        low_bit  = '0;
        cand_any = |cand;
        for (int b = fna_pkg::WORD_W - 1; b >= 0; b--) begin
            if (cand[b]) begin
                low_bit = fna_pkg::BIT_W'(b);
            end
        end
    end

    assign bit_idx = req_reg.number[fna_pkg::BIT_W-1:0];
    assign bad     = {1'b0, req_reg.number} >= size_eff;

    always_comb begin
        rsp_next = '0;
        wr       = 1'b0;
        wdata    = word_data;
        case (req_reg.cmd)
            fna_pkg::CMD_GET: begin
                if (any_free_reg && cand_any) begin
                    rsp_next.granted        = 1'b1;
                    rsp_next.granted_number = {waddr_reg, low_bit};
                    wr                      = 1'b1;
                    wdata = word_data & ~(fna_pkg::WORD_W'(1) << low_bit);
                end
            end
            fna_pkg::CMD_CHECK: begin
                if (bad) begin
                    rsp_next.bad_number = 1'b1;
                end else begin
                    rsp_next.is_free = word_data[bit_idx];
                end
            end
            fna_pkg::CMD_RELEASE: begin
                if (bad) begin
                    rsp_next.bad_number = 1'b1;
                end else begin
                    wr    = 1'b1;
                    wdata = word_data | (fna_pkg::WORD_W'(1) << bit_idx);
                end
            end
            default: begin
                wr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_size_reg <= fna_pkg::SIZE_W'(fna_pkg::POOL_DEPTH);
            valid_reg     <= '0;
            summary_reg   <= '1;
        end else begin
            if (cfg_we) begin
                pool_size_reg <= cfg_wdata;
            end
            if (ctl.commit && wr) begin
                valid_reg[waddr_reg]   <= 1'b1;
                summary_reg[waddr_reg] <= |wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            req_reg      <= s_payload;
            any_free_reg <= |summary_reg;
            if (s_payload.cmd == fna_pkg::CMD_GET) begin
                waddr_reg <= first_word;
            end else begin
                waddr_reg <= s_payload.number[fna_pkg::NUM_W-1:fna_pkg::BIT_W];
            end
        end
        if (ctl.commit) begin
            rsp_reg <= rsp_next;
        end
    end

    assign m_payload = rsp_reg;

endmodule

FILE: rtl/free_number_allocator.sv
// an accepted request passes the read and evaluate states before m_valid rises;
// one transaction at a time: s_ready stays low through the read-modify-write
// of one 32-bit bitmap word in the map ram (read, evaluate and write back);
// a result stalled on m_ready holds the next transaction in evaluate
// reset: synchronous active low; every number free via per-word valid bits,
// no clearing pass, pool_size returns to 1024
module free_number_allocator (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  fna_pkg::req_t              s_payload,
    output logic                       m_valid,
    input  logic                       m_ready,
    output fna_pkg::rsp_t              m_payload,
    input  logic                       cfg_we,
    input  logic [fna_pkg::SIZE_W-1:0] cfg_wdata
);

    fna_pkg::ctl_t ctl;

    fna_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    fna_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .s_payload (s_payload),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_payload (m_payload)
    );

endmodule

FILE: rtl/fna_checker.sv
// port level checks of the free number allocator, bound to the top level
// depends on fna_pkg and free_number_allocator_defines.svh
`include "free_number_allocator_defines.svh"

module fna_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input fna_pkg::rsp_t m_payload
);

    // a stalled result transaction stays up
    `FNA_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid, "result dropped while stalled")
    // one transaction at a time: no back to back acceptance
    `FNA_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "accepted two in a row")
    // a grant never carries check or release flags
    `FNA_ASSERT(a_grant_clean, m_valid && m_payload.granted, !m_payload.is_free && !m_payload.bad_number, "grant with stray flags")
    // no grant means number zero
    `FNA_ASSERT(a_no_grant_zero, m_valid && !m_payload.granted, m_payload.granted_number == '0, "nonzero number without grant")
    // a bad number is never reported free
    `FNA_ASSERT(a_bad_not_free, m_valid && m_payload.bad_number, !m_payload.is_free, "bad number reported free")

endmodule

bind free_number_allocator fna_checker u_fna_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
